/* rtl/bhe_pkg.sv */
// shared types and constants for the bucketed histogram engine
package bhe_pkg;

   localparam int MaxBucketsDefault = 64;

   // function codes
   localparam logic [2:0] FUNC_LOAD   = 3'd0;
   localparam logic [2:0] FUNC_ACC    = 3'd1;
   localparam logic [2:0] FUNC_CNT_S  = 3'd2;
   localparam logic [2:0] FUNC_CNT_I  = 3'd3;
   localparam logic [2:0] FUNC_MERGE  = 3'd4;

   // status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_RANGE    = 2'd1;
   localparam logic [1:0] STATUS_MISMATCH = 2'd2;

   // one queued command
   typedef struct packed {
      logic [2:0]         func;
      logic [6:0]         slot;
      logic signed [31:0] edge_value;
      logic signed [31:0] sample;
      logic signed [31:0] weight;
      logic signed [31:0] entry_low;
      logic signed [31:0] entry_high;
      logic               subtract;
      logic               merge_start;
   } cmd_type;

endpackage

/* rtl/bhe_front.sv */
// front end: command holding queue of two beats
module bhe_front
   import bhe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output cmd_type head_cmd
);

   cmd_type    slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;

   // pointers and fill count
   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      wr_in    = push ? ~wr_ff : wr_ff;
      rd_in    = pop ? ~rd_ff : rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_cmd;
   end

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign head_cmd  = slot_ff[rd_ff];

endmodule

/* rtl/bhe_back.sv */
// back end: sequencer over edge and count memories
module bhe_back
   import bhe_pkg::*;
#(
   parameter int MAX_BUCKETS = MaxBucketsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [6:0]         buckets_in_use,
   input  logic               cmd_valid,
   input  cmd_type            cmd,
   output logic               cmd_pop,
   output logic               idle,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_bucket_count_out,
   output logic [5:0]         rsp_bucket_found,
   output logic signed [63:0] rsp_running_sum,
   output logic signed [31:0] rsp_grand_total,
   output logic [1:0]         rsp_status
);

   localparam int IW = $clog2(MAX_BUCKETS + 1);
   localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LO    = 4'd1;
   localparam logic [3:0] S_HI    = 4'd2;
   localparam logic [3:0] S_RANGE = 4'd3;
   localparam logic [3:0] S_SRCH  = 4'd4;
   localparam logic [3:0] S_CRD   = 4'd5;
   localparam logic [3:0] S_UPD   = 4'd6;
   localparam logic [3:0] S_MRD0  = 4'd7;
   localparam logic [3:0] S_MRD1  = 4'd8;
   localparam logic [3:0] S_MCHK  = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;
   localparam logic [3:0] S_MUL   = 4'd11;

   logic [31:0] edge_mem [MAX_BUCKETS + 1];
   logic [31:0] cnt_mem  [MAX_BUCKETS];
   logic [MAX_BUCKETS-1:0] cnt_valid_ff;

   logic [3:0]         state_ff, state_in;
   cmd_type            cur_ff;
   logic [IW-1:0]      n_ff, lo_ff, hi_ff, cur_idx_ff, mcur_ff;
   logic               mfail_ff;
   logic [IW-1:0]      eaddr;
   logic               ewe;
   logic signed [31:0] erd_ff, elo_ff;
   logic [BW-1:0]      caddr;
   logic [31:0]        crd_ff;
   logic               crd_v_ff;
   logic signed [63:0] sum_ff, prod_ff;
   logic signed [31:0] total_ff, cnt_out_ff;
   logic [5:0]         found_ff;
   logic [1:0]         status_ff;
   logic               rsp_ff;
   logic [IW:0]        mid;
   logic [31:0]        cnt_cur, delta, cnt_new;
   logic               cwe;

   // active bucket count clamp
   logic [IW-1:0] n_eff;
   always_comb begin
      if (buckets_in_use == 7'd0) n_eff = IW'(1);
      else if ({25'd0, buckets_in_use} > MAX_BUCKETS) n_eff = IW'(MAX_BUCKETS);
      else n_eff = IW'(buckets_in_use);
   end

   assign mid     = ({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1;
   assign cnt_cur = crd_v_ff ? crd_ff : 32'd0;
   assign delta   = (cur_ff.func == FUNC_MERGE && cur_ff.subtract) ?
                    (32'd0 - cur_ff.weight) : cur_ff.weight;
   assign cnt_new = cnt_cur + delta;
   assign cwe     = state_ff == S_UPD && (cur_ff.func == FUNC_ACC ||
                    cur_ff.func == FUNC_MERGE);
   assign caddr   = BW'(cur_idx_ff);

   // edge memory address select
   always_comb begin
      ewe   = 1'b0;
      eaddr = IW'(0);
      case (state_ff)
         S_IDLE:  begin
            ewe   = cmd_valid && cmd.func == FUNC_LOAD && {25'd0, cmd.slot} <= MAX_BUCKETS;
            eaddr = IW'(cmd.slot);
            if (cmd.func != FUNC_LOAD) eaddr = IW'(0);
         end
         S_LO:    eaddr = n_ff;
         S_RANGE: eaddr = IW'(mid);
         S_SRCH:  eaddr = IW'(mid);
         S_MUL:   eaddr = IW'(mid);
         S_MRD0:  eaddr = mcur_ff;
         S_MRD1:  eaddr = mcur_ff + IW'(1);
         default: eaddr = IW'(0);
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (ewe) edge_mem[eaddr] <= cmd.edge_value;
      erd_ff <= edge_mem[eaddr];
      if (cwe) cnt_mem[caddr] <= cnt_new;
      crd_ff   <= cnt_mem[caddr];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_valid_ff <= '0;
         sum_ff       <= 64'sd0;
         total_ff     <= 32'sd0;
         mcur_ff      <= IW'(0);
         mfail_ff     <= 1'b0;
         rsp_ff       <= 1'b0;
      end else begin
         rsp_ff <= 1'b0;
         crd_v_ff <= cnt_valid_ff[caddr];
         case (state_ff)
            S_IDLE: if (cmd_valid) begin
               cur_ff     <= cmd;
               n_ff       <= n_eff;
               cnt_out_ff <= 32'sd0;
               found_ff   <= 6'd0;
               status_ff  <= STATUS_OK;
               case (cmd.func)
                  FUNC_LOAD: begin
                     if ({25'd0, cmd.slot} > MAX_BUCKETS) status_ff <= STATUS_RANGE;
                     state_ff <= S_DONE;
                  end
                  FUNC_ACC, FUNC_CNT_S: state_ff <= S_LO;
                  FUNC_CNT_I: begin
                     if (IW'(cmd.slot) < n_eff && {25'd0, cmd.slot} < MAX_BUCKETS) begin
                        cur_idx_ff <= IW'(cmd.slot);
                        state_ff   <= S_CRD;
                     end else begin
                        status_ff <= STATUS_RANGE;
                        state_ff  <= S_DONE;
                     end
                  end
                  FUNC_MERGE: begin
                     if (cmd.merge_start) begin
                        mcur_ff  <= IW'(0);
                        mfail_ff <= 1'b0;
                     end
                     if (mfail_ff && !cmd.merge_start) begin
                        status_ff <= STATUS_MISMATCH;
                        state_ff  <= S_DONE;
                     end else begin
                        state_ff <= S_MRD0;
                     end
                  end
                  default: begin
                     status_ff <= STATUS_RANGE;
                     state_ff  <= S_DONE;
                  end
               endcase
            end
            // edge 0 read issued at idle
            S_LO: begin
               elo_ff <= erd_ff;
               lo_ff  <= IW'(0);
               hi_ff  <= n_ff;
               state_ff <= S_RANGE;
            end
            // edge n now in erd; mid read issued
            S_RANGE: begin
               if (cur_ff.sample < elo_ff || cur_ff.sample >= erd_ff) begin
                  status_ff <= STATUS_RANGE;
                  state_ff  <= S_DONE;
               end else if (hi_ff - lo_ff <= IW'(1)) begin
                  cur_idx_ff <= lo_ff;
                  state_ff   <= S_CRD;
               end else begin
                  state_ff <= S_SRCH;
               end
            end
            // one halving step per pass through S_SRCH and S_MUL; mid edge in erd
            S_SRCH: begin
               if (erd_ff <= cur_ff.sample) lo_ff <= IW'(mid);
               else hi_ff <= IW'(mid);
               state_ff <= S_MUL;
            end
            // next mid read issued here
            S_MUL: begin
               if (hi_ff - lo_ff <= IW'(1)) begin
                  cur_idx_ff <= lo_ff;
                  state_ff   <= S_CRD;
               end else begin
                  state_ff <= S_SRCH;
               end
            end
            S_CRD: begin
               prod_ff  <= 64'(cur_ff.weight) * 64'(cur_ff.sample);
               state_ff <= S_UPD;
            end
            S_UPD: begin
               found_ff <= 6'(cur_idx_ff);
               if (cwe) begin
                  cnt_valid_ff[caddr] <= 1'b1;
                  cnt_out_ff <= cnt_new;
                  total_ff   <= total_ff + delta;
               end else begin
                  cnt_out_ff <= cnt_cur;
               end
               if (cur_ff.func == FUNC_ACC) sum_ff <= sum_ff + prod_ff;
               state_ff <= S_DONE;
            end
            // merge: low edge at cursor
            S_MRD0: state_ff <= S_MRD1;
            S_MRD1: begin
               elo_ff   <= erd_ff;
               state_ff <= S_MCHK;
            end
            S_MCHK: begin
               if (mcur_ff >= n_ff) begin
                  mfail_ff <= 1'b1; status_ff <= STATUS_MISMATCH; state_ff <= S_DONE;
               end else if (cur_ff.entry_low == elo_ff && cur_ff.entry_high == erd_ff) begin
                  cur_idx_ff <= mcur_ff;
                  state_ff   <= S_CRD;
               end else if (cur_ff.entry_low > elo_ff) begin
                  mcur_ff  <= mcur_ff + IW'(1);
                  state_ff <= S_MRD0;
               end else begin
                  mfail_ff <= 1'b1; status_ff <= STATUS_MISMATCH; state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               rsp_ff   <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign cmd_pop              = state_ff == S_IDLE && cmd_valid;
   assign idle                 = state_ff == S_IDLE;
   assign rsp_valid            = rsp_ff;
   assign rsp_bucket_count_out = cnt_out_ff;
   assign rsp_bucket_found     = found_ff;
   assign rsp_running_sum      = sum_ff;
   assign rsp_grand_total      = total_ff;
   assign rsp_status           = status_ff;

endmodule

/* rtl/bucketed_histogram_engine.sv */
// top level of the bucketed histogram engine
//  channel  | ports                          | handshake
//  command  | start, busy, req_*             | accepted when start and not busy
//  result   | rsp_valid, rsp_*               | one-cycle strobe, cannot stall
//  config   | csr_write_en, csr_write_data   | written on enable
// load and bad codes go straight to the done state and the result strobe;
// count by index reads the count memory; accumulate and count by sample check
// the range and, if in range, binary search, one edge memory read per step.
// merge reads the low and high edges at each cursor position; a match updates, a mismatch ends.
// a two-beat queue sits in front of the sequencer.
// synchronous active-high reset; counts reset to zero through valid bits.
module bucketed_histogram_engine
   import bhe_pkg::*;
#(
   parameter int MAX_BUCKETS = MaxBucketsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_func,
   input  logic [6:0]         req_slot,
   input  logic signed [31:0] req_edge_value,
   input  logic signed [31:0] req_sample,
   input  logic signed [31:0] req_weight,
   input  logic signed [31:0] req_entry_low,
   input  logic signed [31:0] req_entry_high,
   input  logic               req_subtract,
   input  logic               req_merge_start,
   input  logic               csr_write_en,
   input  logic [6:0]         csr_write_data,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_bucket_count_out,
   output logic [5:0]         rsp_bucket_found,
   output logic signed [63:0] rsp_running_sum,
   output logic signed [31:0] rsp_grand_total,
   output logic [1:0]         rsp_status
);

   logic [6:0] buckets_ff;
   cmd_type    push_cmd, head_cmd;
   logic       full, not_empty, pop, idle, push;

   // config register
   always_ff @(posedge clock) begin
      if (reset) buckets_ff <= 7'd64;
      else if (csr_write_en) buckets_ff <= csr_write_data;
   end

   assign push     = start && !busy;
   assign busy     = full;
   assign push_cmd = '{req_func, req_slot, req_edge_value, req_sample, req_weight,
                       req_entry_low, req_entry_high, req_subtract, req_merge_start};

   bhe_front u_front (
      .clock, .reset, .push, .push_cmd, .pop, .full, .not_empty, .head_cmd
   );

   bhe_back #(.MAX_BUCKETS(MAX_BUCKETS)) u_back (
      .clock, .reset, .buckets_in_use(buckets_ff), .cmd_valid(not_empty),
      .cmd(head_cmd), .cmd_pop(pop), .idle, .rsp_valid, .rsp_bucket_count_out,
      .rsp_bucket_found, .rsp_running_sum, .rsp_grand_total, .rsp_status
   );

`ifndef SYNTHESIS
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> idle) else $error("pop while sequencer busy");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3) else $error("bad status");
`endif

endmodule

/* tb/bucketed_histogram_engine_tb.sv */
// self-checking testbench for the bucketed histogram engine
`timescale 1ns / 1ps

module bucketed_histogram_engine_tb;
   import bhe_pkg::*;

   localparam int NB = 64;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;

   typedef struct {
      logic signed [31:0] count;
      logic [5:0]         found;
      logic signed [63:0] sum;
      logic signed [31:0] total;
      logic [1:0]         status;
   } hist_result_t;

   typedef struct {
      cmd_type      cmd;
      bit           typed;
      hist_result_t res;
   } stim_row_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_func = FUNC_LOAD;
   logic [6:0]         req_slot = '0;
   logic signed [31:0] req_edge_value = '0;
   logic signed [31:0] req_sample = '0;
   logic signed [31:0] req_weight = '0;
   logic signed [31:0] req_entry_low = '0;
   logic signed [31:0] req_entry_high = '0;
   logic               req_subtract = 1'b0;
   logic               req_merge_start = 1'b0;
   logic               csr_write_en = 1'b0;
   logic [6:0]         csr_write_data = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_bucket_count_out;
   logic [5:0]         rsp_bucket_found;
   logic signed [63:0] rsp_running_sum;
   logic signed [31:0] rsp_grand_total;
   logic [1:0]         rsp_status;

   bucketed_histogram_engine dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic signed [31:0] bound_tbl [0:NB];
   logic signed [31:0] hist_counts [0:NB-1];
   logic signed [63:0] hist_sum;
   logic signed [31:0] hist_total;
   int                 merge_pos;
   bit                 merge_bad;
   logic [6:0]         bucket_reg;

   hist_result_t expected_q [$];
   int           fail_count = 0;
   bit           gaps_on = 1'b1;

   function automatic int active_count();
      if (bucket_reg == 0) return 1;
      if (bucket_reg > NB) return NB;
      return int'(bucket_reg);
   endfunction

   // apply one command beat to the predictor state, return its result
   function automatic hist_result_t histogram_step(cmd_type c);
      hist_result_t r;
      int n, lo, hi, mid;
      bit hit;
      n = active_count();
      r = '{count: '0, found: '0, sum: '0, total: '0, status: STATUS_OK};
      case (c.func)
         FUNC_LOAD: begin
            if (c.slot <= NB) bound_tbl[c.slot] = c.edge_value;
            else r.status = STATUS_RANGE;
         end
         FUNC_ACC, FUNC_CNT_S: begin
            if (c.sample < bound_tbl[0] || c.sample >= bound_tbl[n]) begin
               r.status = STATUS_RANGE;
            end else begin
               lo = 0;
               hi = n;
               while (hi - lo > 1) begin
                  mid = lo + (hi - lo) / 2;
                  if (bound_tbl[mid] <= c.sample) lo = mid;
                  else hi = mid;
               end
               if (c.func == FUNC_ACC) begin
                  hist_counts[lo] += c.weight;
                  hist_total += c.weight;
                  hist_sum += longint'(c.weight) * longint'(c.sample);
               end
               r.found = lo[5:0];
               r.count = hist_counts[lo];
            end
         end
         FUNC_CNT_I: begin
            if (c.slot < n) begin
               r.found = c.slot[5:0];
               r.count = hist_counts[c.slot];
            end else r.status = STATUS_RANGE;
         end
         FUNC_MERGE: begin
            if (c.merge_start) begin
               merge_pos = 0;
               merge_bad = 1'b0;
            end
            if (!merge_bad) begin
               hit = 1'b0;
               while (merge_pos < n) begin
                  if (c.entry_low == bound_tbl[merge_pos] &&
                      c.entry_high == bound_tbl[merge_pos+1]) begin
                     hit = 1'b1;
                     break;
                  end
                  if (c.entry_low > bound_tbl[merge_pos]) merge_pos++;
                  else break;
               end
               if (hit) begin
                  if (c.subtract) begin
                     hist_counts[merge_pos] -= c.weight;
                     hist_total -= c.weight;
                  end else begin
                     hist_counts[merge_pos] += c.weight;
                     hist_total += c.weight;
                  end
                  r.found = merge_pos[5:0];
                  r.count = hist_counts[merge_pos];
               end else merge_bad = 1'b1;
            end
            if (merge_bad) r.status = STATUS_MISMATCH;
         end
         default: r.status = STATUS_RANGE;
      endcase
      r.sum = hist_sum;
      r.total = hist_total;
      return r;
   endfunction

   function automatic cmd_type mk(logic [2:0] f, logic [6:0] s, logic signed [31:0] ev,
                                  logic signed [31:0] smp, logic signed [31:0] w,
                                  logic signed [31:0] lo, logic signed [31:0] hi,
                                  logic sub, logic ms);
      cmd_type c;
      c.func = f;
      c.slot = s;
      c.edge_value = ev;
      c.sample = smp;
      c.weight = w;
      c.entry_low = lo;
      c.entry_high = hi;
      c.subtract = sub;
      c.merge_start = ms;
      return c;
   endfunction

   function automatic logic signed [31:0] rand32();
      return $urandom();
   endfunction

   // drive one command beat, wait for acceptance, record what must come back
   task automatic issue(cmd_type c, bit typed = 1'b0, hist_result_t tr = '{default: '0});
      hist_result_t p;
      if (gaps_on && $urandom_range(0, 99) < 19) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(0, 4)) @(negedge clock);
      end
      @(negedge clock);
      start = 1'b1;
      req_func = c.func;
      req_slot = c.slot;
      req_edge_value = c.edge_value;
      req_sample = c.sample;
      req_weight = c.weight;
      req_entry_low = c.entry_low;
      req_entry_high = c.entry_high;
      req_subtract = c.subtract;
      req_merge_start = c.merge_start;
      do @(posedge clock); while (busy);
      p = histogram_step(c);
      expected_q.push_back(typed ? tr : p);
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_buckets(logic [6:0] v);
      drain();
      csr_write_en = 1'b1;
      csr_write_data = v;
      @(negedge clock);
      csr_write_en = 1'b0;
      bucket_reg = v;
   endtask

   // ascending edge table with random spacing
   task automatic load_ascending();
      logic signed [31:0] v;
      v = -(32'sd1 <<< 30) + $urandom_range(0, 1000);
      for (int i = 0; i <= NB; i++) begin
         issue(mk(FUNC_LOAD, i, v, rand32(), rand32(), rand32(), rand32(),
                  $urandom_range(0, 1), $urandom_range(0, 1)));
         v += $urandom_range(1, 3) == 1 ? $urandom_range(1, 4) : $urandom_range(1, 1 << 24);
      end
   endtask

   function automatic logic signed [31:0] sample_in(int b);
      longint span;
      span = longint'(bound_tbl[b+1]) - longint'(bound_tbl[b]);
      if (span <= 0) return rand32();
      return bound_tbl[b] + $urandom_range(0, span > 32'h7fff_ffff ? 32'h7fff_ffff : span - 1);
   endfunction

   // result beat checker
   always @(posedge clock) begin
      hist_result_t e;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            $display("%0t: result beat with nothing expected", $time);
            fail_count++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_bucket_count_out !== e.count) begin
               $display("%0t: count exp %0d got %0d", $time, e.count, rsp_bucket_count_out);
               fail_count++;
            end
            if (rsp_bucket_found !== e.found) begin
               $display("%0t: found exp %0d got %0d", $time, e.found, rsp_bucket_found);
               fail_count++;
            end
            if (rsp_running_sum !== e.sum) begin
               $display("%0t: sum exp %0d got %0d", $time, e.sum, rsp_running_sum);
               fail_count++;
            end
            if (rsp_grand_total !== e.total) begin
               $display("%0t: total exp %0d got %0d", $time, e.total, rsp_grand_total);
               fail_count++;
            end
            if (rsp_status !== e.status) begin
               $display("%0t: status exp %0d got %0d", $time, e.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("** bucketed_histogram_engine: FAILED **");
      $finish;
   end

   initial begin
      stim_row_t          dir_tab [$];
      hist_result_t       zero_ok, zero_range;
      logic signed [31:0] fixed_bound [0:NB];
      int                 n, b, len;
      bit                 corrupt;
      int                 pick;
      logic [6:0]         phase_cfg [6] = '{7'd0, 7'd1, 7'd127, 7'd17, 7'd2, 7'd64};

      for (int i = 0; i <= NB; i++) bound_tbl[i] = '0;
      for (int i = 0; i < NB; i++) hist_counts[i] = '0;
      hist_sum = '0;
      hist_total = '0;
      merge_pos = 0;
      merge_bad = 1'b0;
      bucket_reg = 7'd64;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fixed table with the 32-bit extremes at both ends
      for (int i = 0; i <= NB; i++)
         fixed_bound[i] = i == 0 ? S32_MIN : i == NB ? S32_MAX : (i - 32) * 1000;
      for (int i = 0; i <= NB; i++)
         issue(mk(FUNC_LOAD, i, fixed_bound[i], 0, 0, 0, 0, 0, 0));

      // directed rows: state is still all zero where the result is typed
      zero_ok = '{count: '0, found: '0, sum: '0, total: '0, status: STATUS_OK};
      zero_range = zero_ok;
      zero_range.status = STATUS_RANGE;
      dir_tab.push_back('{mk(FUNC_CNT_I, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_ok});
      dir_tab.push_back('{mk(FUNC_CNT_I, 64, 0, 0, 0, 0, 0, 0, 0), 1, zero_range});
      dir_tab.push_back('{mk(FUNC_CNT_I, 127, 0, 0, 0, 0, 0, 0, 0), 1, zero_range});
      dir_tab.push_back('{mk(FUNC_LOAD, 127, S32_MAX, 0, 0, 0, 0, 0, 0), 1, zero_range});
      dir_tab.push_back('{mk(FUNC_LOAD, 65, -1, 0, 0, 0, 0, 0, 0), 1, zero_range});
      dir_tab.push_back('{mk(3'd5, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_range});
      dir_tab.push_back('{mk(3'd6, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_range});
      dir_tab.push_back('{mk(3'd7, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_range});
      dir_tab.push_back('{mk(FUNC_CNT_S, 0, 0, S32_MAX, 0, 0, 0, 0, 0), 1, zero_range});
      dir_tab.push_back('{mk(FUNC_ACC, 0, 0, S32_MAX, 5, 0, 0, 0, 0), 1, zero_range});
      dir_tab.push_back('{mk(FUNC_ACC, 0, 0, S32_MIN, S32_MAX, 0, 0, 0, 0), 0, zero_ok});
      dir_tab.push_back('{mk(FUNC_ACC, 0, 0, S32_MAX - 1, S32_MIN, 0, 0, 0, 0), 0, zero_ok});
      dir_tab.push_back('{mk(FUNC_ACC, 0, 0, 0, -1, 0, 0, 0, 0), 0, zero_ok});
      dir_tab.push_back('{mk(FUNC_ACC, 0, 0, 999, 7, 0, 0, 0, 0), 0, zero_ok});
      dir_tab.push_back('{mk(FUNC_CNT_S, 0, 0, 0, 0, 0, 0, 0, 0), 0, zero_ok});
      dir_tab.push_back('{mk(FUNC_CNT_I, 63, 0, 0, 0, 0, 0, 0, 0), 0, zero_ok});
      // merge: matched entries, skip ahead, then a mismatch that sticks
      dir_tab.push_back('{mk(FUNC_MERGE, 0, 0, 0, 5, fixed_bound[0], fixed_bound[1], 0, 1),
                          0, zero_ok});
      dir_tab.push_back('{mk(FUNC_MERGE, 0, 0, 0, 9, fixed_bound[3], fixed_bound[4], 1, 0),
                          0, zero_ok});
      dir_tab.push_back('{mk(FUNC_MERGE, 0, 0, 0, 2, fixed_bound[5], 12345, 0, 0), 0, zero_ok});
      dir_tab.push_back('{mk(FUNC_MERGE, 0, 0, 0, 2, fixed_bound[7], fixed_bound[8], 0, 0),
                          0, zero_ok});
      dir_tab.push_back('{mk(FUNC_MERGE, 0, 0, 0, S32_MIN, fixed_bound[63], fixed_bound[64],
                             1, 1), 0, zero_ok});
      dir_tab.push_back('{mk(FUNC_MERGE, 0, 0, 0, 1, fixed_bound[2], fixed_bound[3], 0, 0),
                          0, zero_ok});
      foreach (dir_tab[i]) issue(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].res);

      // random phases over several bucket settings
      for (int ph = 0; ph < 6; ph++) begin
         write_buckets(phase_cfg[ph]);
         if (ph % 2 == 1) load_ascending();
         gaps_on = (ph != 3);
         n = active_count();
         for (int k = 0; k < 150; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
               b = $urandom_range(0, n - 1);
               issue(mk(FUNC_ACC, $urandom(), rand32(),
                        $urandom_range(0, 4) == 0 ? rand32() : sample_in(b),
                        $urandom_range(0, 3) == 0 ? rand32() : $signed($urandom_range(0, 200)) - 100,
                        rand32(), rand32(), $urandom_range(0, 1), $urandom_range(0, 1)));
            end else if (pick < 45) begin
               b = $urandom_range(0, n - 1);
               issue(mk(FUNC_CNT_S, $urandom(), rand32(),
                        $urandom_range(0, 3) == 0 ? rand32() : sample_in(b),
                        rand32(), rand32(), rand32(), $urandom_range(0, 1), $urandom_range(0, 1)));
            end else if (pick < 55) begin
               issue(mk(FUNC_CNT_I, $urandom_range(0, 1) ? $urandom_range(0, n) : $urandom(),
                        rand32(), rand32(), rand32(), rand32(), rand32(),
                        $urandom_range(0, 1), $urandom_range(0, 1)));
            end else if (pick < 60) begin
               // an occasional stray edge makes the table non-ascending
               issue(mk(FUNC_LOAD, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, NB),
                        rand32(), rand32(), rand32(), rand32(), rand32(),
                        $urandom_range(0, 1), $urandom_range(0, 1)));
            end else if (pick < 62) begin
               issue(mk($urandom_range(5, 7), $urandom(), rand32(), rand32(), rand32(),
                        rand32(), rand32(), $urandom_range(0, 1), $urandom_range(0, 1)));
            end else if (pick < 67) begin
               issue(mk(FUNC_MERGE, $urandom(), rand32(), rand32(), rand32(), rand32(),
                        rand32(), $urandom_range(0, 1), $urandom_range(0, 1)));
            end else begin
               // well-formed ascending merge run, sometimes with one bad entry
               b = $urandom_range(0, n - 1);
               len = $urandom_range(1, 6);
               corrupt = $urandom_range(0, 4) == 0;
               for (int j = 0; j < len && b < n; j++) begin
                  issue(mk(FUNC_MERGE, $urandom(), rand32(), rand32(),
                           $urandom_range(0, 7) == 0 ? rand32() : $urandom_range(0, 50),
                           bound_tbl[b],
                           (corrupt && j == len - 1) ? rand32() : bound_tbl[b+1],
                           $urandom_range(0, 1), j == 0));
                  b += $urandom_range(0, 3);
                  k++;
               end
            end
         end
      end

      drain();
      if (fail_count == 0) $display("** bucketed_histogram_engine: PASSED **");
      else $display("** bucketed_histogram_engine: FAILED **");
      $finish;
   end

endmodule

/* bucketed_histogram_engine.f */
rtl/bhe_pkg.sv
rtl/bhe_front.sv
rtl/bhe_back.sv
rtl/bucketed_histogram_engine.sv
tb/bucketed_histogram_engine_tb.sv
